// ===== design/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package mcr_pkg;

  // Field widths of the stream beats.
  localparam int ColW      = 7;
  localparam int RowW      = 6;
  localparam int RadW      = 5;
  localparam int OffW      = 6;
  localparam int DecW      = 10;
  localparam int PixColW   = 9;
  localparam int PixRowW   = 8;
  localparam int InFieldW  = ColW + RowW + RadW;
  localparam int InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW = 4 * (PixColW + PixRowW);
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Result budget per circle; two results per loop step.
  localparam int MaxResults = 46;
  localparam int MaxSteps   = MaxResults / 2;
  localparam int StepW      = $clog2(MaxSteps);

  // Decision term constants of the midpoint recurrence.
  localparam logic [DecW-1:0] DecInit  = DecW'(3);
  localparam logic [DecW-1:0] DecIncLo = DecW'(6);
  localparam logic [DecW-1:0] DecIncHi = DecW'(10);

  // Controller to datapath commands.
  typedef struct packed {
    logic start;  // load a new circle request
    logic emit;   // capture one result into the output register
  } mcr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
    logic last;      // the result emitted now closes the circle
  } mcr_status_t;

endpackage

// ===== design/midpoint_circle_rasterizer_top.sv =====
// Top level of the midpoint circle rasterizer: controller plus datapath.
// Depends on mcr_pkg, mcr_ctrl and mcr_dpath.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one circle request per beat. The master stream
// returns the circle as beats of four pixels each; every loop step of the
// midpoint recurrence yields two beats, the second with tuser set (x and y
// swapped). The final beat of a circle carries tlast.
// A circle of radius r takes about r/sqrt(2) + 1 loop steps, at most 23,
// so it yields up to 46 beats. The single octant loop in the datapath
// produces one beat per cycle when the receiver keeps tready high.
// After a request is accepted the controller enters its run state, and the
// first beat is then captured into the output register and offered. A new
// request is accepted as soon as the last beat of the previous circle sits
// in the output register, even if that beat is still stalled.
// A stalled receiver holds the output register and pauses the loop; no
// beat is lost or repeated. Reset returns the block to idle with no beat
// pending.
module midpoint_circle_rasterizer_top #(
  parameter int MAX_RADIUS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: center_col[6:0], center_row[5:0], radius[4:0], zero pad.
  input  logic [mcr_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: pix0_col, pix0_row, pix1_col, pix1_row, pix2_col,
  // pix2_row, pix3_col, pix3_row (cols 9 bits, rows 8 bits, signed), zero pad.
  output logic [mcr_pkg::OutDataW-1:0]      m_axis_tdata,
  // Fields from bit 0: swapped_half.
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mcr_pkg::*;

  mcr_cmd_t    cmd;
  mcr_status_t status;

  mcr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  mcr_dpath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/mcr_ctrl.sv =====
// Control state machine of the midpoint circle rasterizer.
// Depends on mcr_pkg for the command and status structs.
`timescale 1ns / 1ps

module mcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  mcr_pkg::mcr_status_t status_i,
  output mcr_pkg::mcr_cmd_t    cmd_o
);
  import mcr_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  assign s_axis_tready = (state_q == StIdle);
  assign cmd_o.start   = s_axis_tvalid && (state_q == StIdle);
  assign cmd_o.emit    = (state_q == StRun) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.start) state_d = StRun;
      end
      StRun: begin
        if (cmd_o.emit && status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/mcr_dpath.sv =====
// Datapath of the midpoint circle rasterizer: octant offsets, decision term,
// pixel adders and the output register. Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_dpath #(
  parameter int MAX_RADIUS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcr_pkg::mcr_cmd_t                 cmd_i,
  output mcr_pkg::mcr_status_t              status_o,
  input  logic [mcr_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mcr_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mcr_pkg::*;

  logic [ColW-1:0]  in_col;
  logic [RowW-1:0]  in_row;
  logic [RadW-1:0]  in_rad;
  logic [RadW-1:0]  rad_sat;

  logic [OffW-1:0]  x_q, y_q;
  logic [DecW-1:0]  d_q;
  logic [ColW-1:0]  cc_q;
  logic [RowW-1:0]  cr_q;
  logic             half_q;
  logic [StepW-1:0] step_q;

  logic [OffW-1:0]  a, b;
  logic [OffW-1:0]  x_nx;
  logic [OffW:0]    y_nx;
  logic [DecW-1:0]  d_nx, x4, y4;
  logic             d_neg;
  logic             loop_done;

  logic [PixColW-1:0] col_p, col_m;
  logic [PixRowW-1:0] row_p, row_m;

  logic                valid_q;
  logic [OutDataW-1:0] data_q;
  logic                user_q, last_q;

  assign in_col = s_axis_tdata[ColW-1:0];
  assign in_row = s_axis_tdata[ColW+RowW-1:ColW];
  assign in_rad = s_axis_tdata[InFieldW-1:ColW+RowW];

  // The radius saturates to the configured maximum.
  assign rad_sat = ({2'b00, in_rad} > 7'(MAX_RADIUS)) ? RadW'(MAX_RADIUS) : in_rad;

  // The second half of a step swaps the roles of x and y.
  assign a = half_q ? y_q : x_q;
  assign b = half_q ? x_q : y_q;

  assign col_p = {2'b00, cc_q} + {3'b000, a};
  assign col_m = {2'b00, cc_q} - {3'b000, a};
  assign row_p = {2'b00, cr_q} + {2'b00, b};
  assign row_m = {2'b00, cr_q} - {2'b00, b};

  assign x4    = {2'b00, x_q, 2'b00};
  assign y4    = {2'b00, y_q, 2'b00};
  assign d_neg = d_q[DecW-1];
  assign d_nx  = d_neg ? (d_q + x4 + DecIncLo) : (d_q + x4 - y4 + DecIncHi);
  assign x_nx  = x_q + OffW'(1);
  // One extra bit so that y stepping below zero still ends the loop.
  assign y_nx  = d_neg ? {1'b0, y_q} : ({1'b0, y_q} - 7'd1);

  assign loop_done = ($signed({1'b0, x_nx}) > $signed(y_nx))
                  || (step_q == StepW'(MaxSteps - 1));

  assign status_o.last     = half_q && loop_done;
  assign status_o.out_free = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= 1'b0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        half_q <= 1'b0;
        step_q <= '0;
      end else if (cmd_i.emit) begin
        half_q <= !half_q;
        if (half_q) step_q <= step_q + StepW'(1);
      end
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q  <= '0;
      y_q  <= {1'b0, rad_sat};
      d_q  <= DecInit - {4'b0000, rad_sat, 1'b0};
      cc_q <= in_col;
      cr_q <= in_row;
    end else if (cmd_i.emit && half_q) begin
      x_q <= x_nx;
      y_q <= y_nx[OffW-1:0];
      d_q <= d_nx;
    end
    if (cmd_i.emit) begin
      data_q <= {(OutDataW - OutFieldW)'(0),
                 row_m, col_m, row_m, col_p, row_p, col_m, row_p, col_p};
      user_q <= half_q;
      last_q <= half_q && loop_done;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== design/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasterizer, bound to the top.
// Depends on mcr_pkg and midpoint_circle_rasterizer_top.
`timescale 1ns / 1ps

module mcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mcr_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import mcr_pkg::*;

  // A stalled result beat stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // The contents of a stalled result beat do not change.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("result beat changed while stalled");

  // The circle always closes on the swapped half of a step.
  a_last_swapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last beat on an unswapped half");

  // Once a request is taken, the block is busy with it in the next cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted on consecutive cycles");

  // An idle block produces nothing new once its pending beat is drained.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result beat produced while idle");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/circle_pixel_checker.sv =====
// Scoreboard for the midpoint circle rasterizer: watches both streams,
// predicts the pixel beats of every accepted circle and compares them.
// Depends on mcr_pkg for the stream widths and the result budget.
`timescale 1ns / 1ps

module circle_pixel_checker #(
  parameter int MAX_RADIUS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [mcr_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [mcr_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         m_axis_tuser,
  input  logic                         m_axis_tlast,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           circles_o,
  output int                           beats_o
);
  import mcr_pkg::*;

  localparam int PixW = PixColW + PixRowW;

  typedef struct packed {
    logic [3:0][PixColW-1:0] col;
    logic [3:0][PixRowW-1:0] row;
    logic                    swapped;
    logic                    last;
  } pixel_beat_t;

  pixel_beat_t expected_beats[$];
  int          failures = 0;
  int          circles  = 0;
  int          beats    = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    circles_o    = 0;
    beats_o      = 0;
  end

  function automatic pixel_beat_t octant_points(input int cc, input int cr, input int a,
                                                input int b, input logic swapped,
                                                input logic last);
    pixel_beat_t bt;
    bt.col[0]  = PixColW'(cc + a);
    bt.row[0]  = PixRowW'(cr + b);
    bt.col[1]  = PixColW'(cc - a);
    bt.row[1]  = PixRowW'(cr + b);
    bt.col[2]  = PixColW'(cc + a);
    bt.row[2]  = PixRowW'(cr - b);
    bt.col[3]  = PixColW'(cc - a);
    bt.row[3]  = PixRowW'(cr - b);
    bt.swapped = swapped;
    bt.last    = last;
    return bt;
  endfunction

  // Runs the whole octant loop for one request and queues its beats.
  task automatic rasterize_circle(input logic [ColW-1:0] center_col,
                                  input logic [RowW-1:0] center_row,
                                  input logic [RadW-1:0] radius);
    int x;
    int y;
    int d;
    int nx;
    int ny;
    int nd;
    int n;
    int r;
    logic closing;
    r = int'(radius);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    x = 0;
    y = r;
    d = 3 - 2 * r;
    n = 0;
    while (x <= y && n + 2 <= MaxResults) begin
      if (d < 0) begin
        nd = d + 4 * x + 6;
        ny = y;
      end else begin
        nd = d + 4 * (x - y) + 10;
        ny = y - 1;
      end
      nx = x + 1;
      // The second beat of this step closes the circle if the loop stops here.
      closing = !(nx <= ny && n + 4 <= MaxResults);
      expected_beats.push_back(octant_points(int'(center_col), int'(center_row),
                                             x, y, 1'b0, 1'b0));
      expected_beats.push_back(octant_points(int'(center_col), int'(center_row),
                                             y, x, 1'b1, closing));
      n += 2;
      x = nx;
      y = ny;
      d = nd;
    end
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats++;
        if (expected_beats.size() == 0) begin
          failures++;
          $display("%0t: unexpected beat, expected none, actual tdata %h", $time,
                   m_axis_tdata);
        end else begin
          want = expected_beats.pop_front();
          for (int i = 0; i < 4; i++) begin
            check_field($sformatf("pix%0d_col", i), $signed(want.col[i]),
                        $signed(m_axis_tdata[i*PixW +: PixColW]));
            check_field($sformatf("pix%0d_row", i), $signed(want.row[i]),
                        $signed(m_axis_tdata[i*PixW+PixColW +: PixRowW]));
          end
          check_field("swapped_half", want.swapped, m_axis_tuser);
          check_field("last_of_run", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        circles++;
        rasterize_circle(s_axis_tdata[ColW-1:0], s_axis_tdata[ColW +: RowW],
                         s_axis_tdata[ColW+RowW +: RadW]);
      end
    end
    fail_count_o <= failures;
    pending_o    <= expected_beats.size();
    circles_o    <= circles;
    beats_o      <= beats;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the rasterizer bench: clock, reset, request and backpressure stimulus.
// Depends on mcr_pkg, midpoint_circle_rasterizer_top and circle_pixel_checker.
`timescale 1ns / 1ps

module testbench;
  import mcr_pkg::*;

  localparam int RandomCircles = 400;
  localparam int IdleLimit     = 2000;
  localparam int HoldOffCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int   fail_count;
  int   pending;
  int   circles;
  int   beats;
  int   idle_cycles = 0;
  bit   sender_gaps   = 1'b1;
  bit   receiver_gaps = 1'b1;
  bit   hold_off_req  = 1'b0;

  always #1 clk_i = ~clk_i;

  midpoint_circle_rasterizer_top #(
    .MAX_RADIUS(31)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  circle_pixel_checker #(
    .MAX_RADIUS(31)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .circles_o    (circles),
    .beats_o      (beats)
  );

  // Offers one circle request and returns at the edge where it is taken.
  // A zero gap keeps tvalid high straight into the next beat.
  task automatic send_circle(input int center_col, input int center_row, input int radius);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({RadW'(radius), RowW'(center_row), ColW'(center_col)});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Receiver: random stalls per beat, plus one long hold-off on request.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      gap = receiver_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles with no beat moving on either stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d idle cycles with %0d beats outstanding.",
                 idle_cycles, pending);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int sel;
    int radius;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners of the screen with the smallest and largest radius, a few small radii
    // where the axis and diagonal pixels repeat, then larger radii near edges and inside.
    send_circle(0, 0, 0);
    send_circle(127, 63, 0);
    send_circle(0, 0, 31);
    send_circle(127, 63, 31);
    send_circle(64, 32, 1);
    send_circle(64, 32, 2);
    send_circle(64, 32, 3);
    send_circle(1, 1, 4);
    send_circle(127, 0, 15);
    send_circle(0, 63, 16);
    send_circle(85, 42, 21);
    send_circle(42, 21, 10);
    send_circle(10, 50, 31);

    for (int i = 0; i < RandomCircles; i++) begin
      // Switch idling patterns now and then; the first stretch runs without gaps.
      if (i == 0) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end else if (i % 50 == 0) begin
        sender_gaps   = $urandom_range(0, 3) != 0;
        receiver_gaps = $urandom_range(0, 3) != 0;
      end
      if (i == 200) begin
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
      end
      sel = $urandom_range(0, 9);
      radius = (sel == 0) ? 0 : (sel == 1) ? 31 : $urandom_range(0, 31);
      send_circle($urandom_range(0, 127), $urandom_range(0, 63), radius);
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d circle requests with radii 0 to 31 at screen corners and random",
             circles);
    $display("centers, %0d pixel beats checked under random and long output stalls.", beats);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mcr_pkg.sv
design/mcr_ctrl.sv
design/mcr_dpath.sv
design/midpoint_circle_rasterizer_top.sv
design/mcr_checker.sv
bench/circle_pixel_checker.sv
bench/testbench.sv
